// ===== src/imu_oc_pkg.sv =====
// shared types and constants for the imu offset calibrator
`timescale 1ns / 1ps
`default_nettype none

package imu_oc_pkg;

   localparam int AXIS_W     = 16;
   localparam int NUM_AXES   = 6;
   localparam int NUM_ACCEL  = 3;
   localparam int ACCEL_Z    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MODE_W     = 2;

   localparam int DEF_SAMPLES_PER_ITER = 64;
   localparam int DEF_NUM_ITERATIONS   = 6;

   localparam int GRAVITY_1G = 16384;
   localparam int ACCEL_DIV  = 6;
   localparam int GYRO_DIV   = 3;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ACCEL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ACCEL_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ACCEL_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_MODE    = 2'd3;

   localparam int MODE_ACCEL_BIT = 0;
   localparam int MODE_GYRO_BIT  = 1;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'b11;

   typedef logic signed [AXIS_W-1:0] axis_type;

endpackage

`default_nettype wire

// ===== src/imu_offset_calibrator_core.sv =====
// imu offset calibrator top level: sample accumulation and offset update
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_cmd, six raw readings
// rsp       out        rsp_valid / rsp_ready  six offsets, write flags, last
// csr       in         csr_wr_en              csr_index, csr_wdata
//
// one transaction per cycle unless stalled: input register, then accumulate or update, then result register
// an update multiplies each axis sum by a constant reciprocal in that single pass
// rsp_valid is registered and rises once an update transaction in the input register is processed
// reset is synchronous; after reset the block is idle until a start transaction
// req_ready drops only while an update transaction waits on a full result register

module imu_offset_calibrator_core
   import imu_oc_pkg::*;
#(
   parameter int SAMPLES_PER_ITER = DEF_SAMPLES_PER_ITER,
   parameter int NUM_ITERATIONS   = DEF_NUM_ITERATIONS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_cmd,
   input  wire logic signed [15:0]    req_accel_x,
   input  wire logic signed [15:0]    req_accel_y,
   input  wire logic signed [15:0]    req_accel_z,
   input  wire logic signed [15:0]    req_gyro_x,
   input  wire logic signed [15:0]    req_gyro_y,
   input  wire logic signed [15:0]    req_gyro_z,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [15:0]         rsp_off_accel_x,
   output logic signed [15:0]         rsp_off_accel_y,
   output logic signed [15:0]         rsp_off_accel_z,
   output logic signed [15:0]         rsp_off_gyro_x,
   output logic signed [15:0]         rsp_off_gyro_y,
   output logic signed [15:0]         rsp_off_gyro_z,
   output logic                       rsp_accel_write,
   output logic                       rsp_gyro_write,
   output logic                       rsp_last,

   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W   = $clog2(SAMPLES_PER_ITER) + 17;
   localparam int MAG_W   = SUM_W;
   localparam int RECIP_W = MAG_W + 2;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam int CNT_W   = $clog2(SAMPLES_PER_ITER + 1);
   localparam int ITER_W  = $clog2(NUM_ITERATIONS + 1);

   localparam int ACC_DEN    = SAMPLES_PER_ITER * ACCEL_DIV;
   localparam int GYRO_DEN   = SAMPLES_PER_ITER * GYRO_DIV;
   localparam int ACC_SHIFT  = MAG_W + $clog2(ACC_DEN);
   localparam int GYRO_SHIFT = MAG_W + $clog2(GYRO_DEN);
   localparam logic [RECIP_W-1:0] ACC_RECIP =
      RECIP_W'(((64'd1 << ACC_SHIFT) + 64'(ACC_DEN) - 64'd1) / 64'(ACC_DEN));
   localparam logic [RECIP_W-1:0] GYRO_RECIP =
      RECIP_W'(((64'd1 << GYRO_SHIFT) + 64'(GYRO_DEN) - 64'd1) / 64'(GYRO_DEN));
   localparam logic signed [SUM_W-1:0] Z_BIAS = SUM_W'(SAMPLES_PER_ITER * GRAVITY_1G);

   // csr registers
   axis_type          start_off_ff [NUM_ACCEL];
   logic [MODE_W-1:0] write_mode_ff;

   // input register
   logic     in_valid_ff;
   logic     in_valid_in;
   logic     in_cmd_ff;
   axis_type in_data_ff [NUM_AXES];
   axis_type req_data [NUM_AXES];

   // calibration state
   logic signed [SUM_W-1:0] sum_ff [NUM_AXES];
   logic signed [SUM_W-1:0] sum_in [NUM_AXES];
   axis_type                off_ff [NUM_AXES];
   axis_type                off_in [NUM_AXES];
   axis_type                upd_off [NUM_AXES];
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;
   logic [ITER_W-1:0]       iter_ff;
   logic [ITER_W-1:0]       iter_in;
   logic [ITER_W-1:0]       iter_next;
   logic                    running_ff;
   logic                    running_in;

   // result register
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   axis_type rsp_off_ff [NUM_AXES];
   logic     rsp_accel_write_ff;
   logic     rsp_gyro_write_ff;
   logic     rsp_last_ff;

   logic is_update;
   logic proc;
   logic last_iter;

   logic                 sum_neg [NUM_AXES];
   logic [MAG_W-1:0]     sum_mag [NUM_AXES];
   logic [PROD_W-1:0]    quot_prod [NUM_AXES];
   logic [AXIS_W-1:0]    quot_mag [NUM_AXES];

   assign req_data[0] = req_accel_x;
   assign req_data[1] = req_accel_y;
   assign req_data[2] = req_accel_z;
   assign req_data[3] = req_gyro_x;
   assign req_data[4] = req_gyro_y;
   assign req_data[5] = req_gyro_z;

   assign is_update = (in_cmd_ff == CMD_SAMPLE) && running_ff
                      && (cnt_ff == CNT_W'(SAMPLES_PER_ITER));
   assign proc      = in_valid_ff && (!is_update || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !proc);

   assign iter_next = iter_ff + 1'b1;
   assign last_iter = (iter_next == ITER_W'(NUM_ITERATIONS));

   // offset update by constant reciprocal, truncated toward zero
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sum_neg[i] = sum_ff[i][SUM_W-1];
         sum_mag[i] = sum_neg[i] ? (~$unsigned(sum_ff[i]) + 1'b1) : $unsigned(sum_ff[i]);
         if (i < NUM_ACCEL) begin
            quot_prod[i] = PROD_W'(sum_mag[i]) * PROD_W'(ACC_RECIP);
            quot_mag[i]  = AXIS_W'(quot_prod[i] >> ACC_SHIFT);
         end else begin
            quot_prod[i] = PROD_W'(sum_mag[i]) * PROD_W'(GYRO_RECIP);
            quot_mag[i]  = AXIS_W'(quot_prod[i] >> GYRO_SHIFT);
         end
         upd_off[i] = sum_neg[i] ? (off_ff[i] + $signed(quot_mag[i]))
                                 : (off_ff[i] - $signed(quot_mag[i]));
      end
   end

   always_comb begin
      sum_in     = sum_ff;
      off_in     = off_ff;
      cnt_in     = cnt_ff;
      iter_in    = iter_ff;
      running_in = running_ff;
      if (in_cmd_ff == CMD_START) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_in[i] = (i == ACCEL_Z) ? Z_BIAS : '0;
            off_in[i] = (i < NUM_ACCEL) ? start_off_ff[i] : '0;
         end
         cnt_in     = '0;
         iter_in    = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (is_update) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               sum_in[i] = (i == ACCEL_Z) ? Z_BIAS : '0;
               off_in[i] = upd_off[i];
            end
            cnt_in  = '0;
            iter_in = iter_next;
            if (last_iter) begin
               running_in = 1'b0;
            end
         end else begin
            for (int i = 0; i < NUM_AXES; i++) begin
               sum_in[i] = sum_ff[i] + SUM_W'(in_data_ff[i]);
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = (proc && is_update) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_off_ff[0] <= '0;
         start_off_ff[1] <= '0;
         start_off_ff[2] <= '0;
         write_mode_ff   <= MODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_ACCEL_X: start_off_ff[0] <= axis_type'(csr_wdata);
            CSR_START_ACCEL_Y: start_off_ff[1] <= axis_type'(csr_wdata);
            CSR_START_ACCEL_Z: start_off_ff[2] <= axis_type'(csr_wdata);
            CSR_WRITE_MODE:    write_mode_ff   <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         cnt_ff       <= '0;
         iter_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            running_ff <= running_in;
            cnt_ff     <= cnt_in;
            iter_ff    <= iter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_data_ff <= req_data;
      end
      if (proc) begin
         sum_ff <= sum_in;
         off_ff <= off_in;
      end
      if (proc && is_update) begin
         rsp_off_ff         <= upd_off;
         rsp_accel_write_ff <= write_mode_ff[MODE_ACCEL_BIT];
         rsp_gyro_write_ff  <= write_mode_ff[MODE_GYRO_BIT];
         rsp_last_ff        <= last_iter;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_off_accel_x = rsp_off_ff[0];
   assign rsp_off_accel_y = rsp_off_ff[1];
   assign rsp_off_accel_z = rsp_off_ff[2];
   assign rsp_off_gyro_x  = rsp_off_ff[3];
   assign rsp_off_gyro_y  = rsp_off_ff[4];
   assign rsp_off_gyro_z  = rsp_off_ff[5];
   assign rsp_accel_write = rsp_accel_write_ff;
   assign rsp_gyro_write  = rsp_gyro_write_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the imu offset calibrator core
`timescale 1ns / 1ps

module tb;
   import imu_oc_pkg::*;

   localparam int NUM_RUNS      = 4;
   localparam int DRAIN_CYCLES  = 6;
   localparam int STALL_LIMIT   = 1000;
   localparam int RUN_SAMPLES   = DEF_SAMPLES_PER_ITER + 1;

   typedef logic [NUM_AXES-1:0][AXIS_W-1:0] reading_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][AXIS_W-1:0] off;
      logic                            accel_write;
      logic                            gyro_write;
      logic                            last;
   } offset_rsp_type;

   class offset_tracker;
      logic [AXIS_W-1:0] start_accel[NUM_ACCEL];
      logic [MODE_W-1:0] mode;
      longint            sums[NUM_AXES];
      logic [AXIS_W-1:0] offs[NUM_AXES];
      int                sample_cnt;
      int                iter_cnt;
      bit                active;
      offset_rsp_type    pending_offsets[$];
      int                errors;
      string             axis_name[NUM_AXES];

      function new();
         int i;
         for (i = 0; i < NUM_ACCEL; i++) start_accel[i] = '0;
         for (i = 0; i < NUM_AXES; i++) begin
            sums[i] = 0;
            offs[i] = '0;
         end
         mode       = MODE_RESET;
         sample_cnt = 0;
         iter_cnt   = 0;
         active     = 1'b0;
         errors     = 0;
         axis_name  = '{"off_accel_x", "off_accel_y", "off_accel_z",
                        "off_gyro_x", "off_gyro_y", "off_gyro_z"};
      endfunction

      function int pending();
         return pending_offsets.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_START_ACCEL_X: start_accel[0] = data[AXIS_W-1:0];
            CSR_START_ACCEL_Y: start_accel[1] = data[AXIS_W-1:0];
            CSR_START_ACCEL_Z: start_accel[2] = data[AXIS_W-1:0];
            CSR_WRITE_MODE:    mode = data[MODE_W-1:0];
            default: ;
         endcase
      endfunction

      function void clear_sums();
         int i;
         for (i = 0; i < NUM_AXES; i++) sums[i] = 0;
         sample_cnt = 0;
      endfunction

      function void note_command(logic cmd, reading_type rd);
         int             i;
         longint         num;
         longint         den;
         longint         quo;
         offset_rsp_type upd;
         if (cmd == CMD_START) begin
            for (i = 0; i < NUM_AXES; i++)
               offs[i] = (i < NUM_ACCEL) ? start_accel[i] : '0;
            clear_sums();
            iter_cnt = 0;
            active   = 1'b1;
            return;
         end
         if (!active) return;
         if (sample_cnt < DEF_SAMPLES_PER_ITER) begin
            for (i = 0; i < NUM_AXES; i++) sums[i] += longint'($signed(rd[i]));
            sample_cnt++;
            return;
         end
         // the sample that triggers the update is dropped
         for (i = 0; i < NUM_AXES; i++) begin
            num = sums[i];
            den = DEF_SAMPLES_PER_ITER * ((i < NUM_ACCEL) ? ACCEL_DIV : GYRO_DIV);
            if (i == ACCEL_Z) num += longint'(GRAVITY_1G) * DEF_SAMPLES_PER_ITER;
            quo = num / den;
            offs[i] = offs[i] - quo[AXIS_W-1:0];
            upd.off[i] = offs[i];
         end
         clear_sums();
         iter_cnt++;
         upd.accel_write = mode[MODE_ACCEL_BIT];
         upd.gyro_write  = mode[MODE_GYRO_BIT];
         upd.last        = (iter_cnt >= DEF_NUM_ITERATIONS);
         if (upd.last) active = 1'b0;
         pending_offsets.push_back(upd);
      endfunction

      function void check_update(offset_rsp_type got);
         offset_rsp_type want;
         int             i;
         if (pending_offsets.size() == 0) begin
            $error("offset update with none outstanding");
            errors++;
            return;
         end
         want = pending_offsets.pop_front();
         for (i = 0; i < NUM_AXES; i++) begin
            if (got.off[i] !== want.off[i]) begin
               $error("%s expected %0d actual %0d", axis_name[i],
                      $signed(want.off[i]), $signed(got.off[i]));
               errors++;
            end
         end
         if (got.accel_write !== want.accel_write) begin
            $error("accel_write expected %0d actual %0d", want.accel_write, got.accel_write);
            errors++;
         end
         if (got.gyro_write !== want.gyro_write) begin
            $error("gyro_write expected %0d actual %0d", want.gyro_write, got.gyro_write);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic signed [15:0]    req_accel_x;
   logic signed [15:0]    req_accel_y;
   logic signed [15:0]    req_accel_z;
   logic signed [15:0]    req_gyro_x;
   logic signed [15:0]    req_gyro_y;
   logic signed [15:0]    req_gyro_z;

   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [15:0]    rsp_off_accel_x;
   logic signed [15:0]    rsp_off_accel_y;
   logic signed [15:0]    rsp_off_accel_z;
   logic signed [15:0]    rsp_off_gyro_x;
   logic signed [15:0]    rsp_off_gyro_y;
   logic signed [15:0]    rsp_off_gyro_z;
   logic                  rsp_accel_write;
   logic                  rsp_gyro_write;
   logic                  rsp_last;

   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   offset_tracker  tracker;
   offset_rsp_type seen_update;
   bit             quiet;
   int             ready_hold;
   int             stall_count;
   int             axis_bias[NUM_AXES];

   imu_offset_calibrator_core #(
      .SAMPLES_PER_ITER(DEF_SAMPLES_PER_ITER),
      .NUM_ITERATIONS  (DEF_NUM_ITERATIONS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .req_gyro_x     (req_gyro_x),
      .req_gyro_y     (req_gyro_y),
      .req_gyro_z     (req_gyro_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_off_accel_x(rsp_off_accel_x),
      .rsp_off_accel_y(rsp_off_accel_y),
      .rsp_off_accel_z(rsp_off_accel_z),
      .rsp_off_gyro_x (rsp_off_gyro_x),
      .rsp_off_gyro_y (rsp_off_gyro_y),
      .rsp_off_gyro_z (rsp_off_gyro_z),
      .rsp_accel_write(rsp_accel_write),
      .rsp_gyro_write (rsp_gyro_write),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_ready  = 1'b0;
      ready_hold = 0;
   end

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         ready_hold = $urandom_range(1, 3) - 1;
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_update.off[0]      = rsp_off_accel_x;
         seen_update.off[1]      = rsp_off_accel_y;
         seen_update.off[2]      = rsp_off_accel_z;
         seen_update.off[3]      = rsp_off_gyro_x;
         seen_update.off[4]      = rsp_off_gyro_y;
         seen_update.off[5]      = rsp_off_gyro_z;
         seen_update.accel_write = rsp_accel_write;
         seen_update.gyro_write  = rsp_gyro_write;
         seen_update.last        = rsp_last;
         tracker.check_update(seen_update);
      end
   end

   initial begin
      stall_count = 0;
      while (stall_count < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_count = 0;
         else
            stall_count++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic reading_type random_reading();
      reading_type rd;
      int          i;
      for (i = 0; i < NUM_AXES; i++) rd[i] = AXIS_W'($urandom);
      return rd;
   endfunction

   function automatic reading_type flat_reading(logic [AXIS_W-1:0] value);
      reading_type rd;
      int          i;
      for (i = 0; i < NUM_AXES; i++) rd[i] = value;
      return rd;
   endfunction

   function automatic reading_type make_sample(int style);
      reading_type rd;
      int          i;
      case (style)
         0: rd = random_reading();
         1: rd = flat_reading(16'h7fff);
         2: rd = flat_reading(16'h8000);
         default: begin
            for (i = 0; i < NUM_AXES; i++)
               rd[i] = AXIS_W'(axis_bias[i] + int'($urandom_range(0, 128)) - 64);
         end
      endcase
      return rd;
   endfunction

   function automatic logic [AXIS_W-1:0] pick_offset();
      case ($urandom_range(0, 3))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return AXIS_W'($urandom);
      endcase
   endfunction

   task automatic push_req(logic cmd, reading_type rd);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_accel_x = rd[0];
      req_accel_y = rd[1];
      req_accel_z = rd[2];
      req_gyro_x  = rd[3];
      req_gyro_y  = rd[4];
      req_gyro_z  = rd[5];
      do @(posedge clock); while (!req_ready);
      tracker.note_command(cmd, rd);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic setup_run(int run_idx);
      logic [AXIS_W-1:0] offset_val[NUM_ACCEL];
      logic [MODE_W-1:0] mode_val;
      int                i;
      drain();
      for (i = 0; i < NUM_ACCEL; i++) begin
         case (run_idx)
            1: offset_val[i] = 16'h7fff;
            2: offset_val[i] = 16'h8000;
            3: offset_val[i] = '0;
            default: offset_val[i] = pick_offset();
         endcase
      end
      mode_val = (run_idx <= 3) ? MODE_W'(run_idx - 1) : MODE_W'($urandom_range(0, 3));
      write_csr(CSR_START_ACCEL_X, offset_val[0]);
      write_csr(CSR_START_ACCEL_Y, offset_val[1]);
      write_csr(CSR_START_ACCEL_Z, offset_val[2]);
      write_csr(CSR_WRITE_MODE, CSR_DATA_W'(mode_val));
   endtask

   task automatic run_calibration();
      int n;
      int style;
      int sel;
      int i;
      push_req(CMD_START, random_reading());
      n     = 0;
      style = 0;
      while (tracker.active) begin
         if (n % RUN_SAMPLES == 0) begin
            sel   = $urandom_range(0, 9);
            style = (sel < 4) ? 0 : (sel == 4) ? 1 : (sel == 5) ? 2 : 3;
            for (i = 0; i < NUM_AXES; i++)
               axis_bias[i] = int'($urandom_range(0, 64000)) - 32000;
         end
         // occasional restart in the middle of a run
         if ($urandom_range(0, 999) == 0)
            push_req(CMD_START, random_reading());
         else
            push_req(CMD_SAMPLE, make_sample(style));
         n++;
      end
      repeat ($urandom_range(0, 3)) push_req(CMD_SAMPLE, random_reading());
   endtask

   initial begin
      int run_idx;
      tracker     = new();
      quiet       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_SAMPLE;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_gyro_x  = '0;
      req_gyro_y  = '0;
      req_gyro_z  = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_START_ACCEL_X;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // samples before any start are ignored
      push_req(CMD_SAMPLE, flat_reading(16'h7fff));
      push_req(CMD_SAMPLE, flat_reading(16'h8000));
      push_req(CMD_START, flat_reading(16'h7fff));
      push_req(CMD_SAMPLE, flat_reading(16'h7fff));
      push_req(CMD_SAMPLE, flat_reading(16'h8000));
      push_req(CMD_SAMPLE, flat_reading(16'h0000));
      push_req(CMD_SAMPLE, flat_reading(16'hffff));
      push_req(CMD_SAMPLE, {16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h8000, 16'h7fff});
      push_req(CMD_SAMPLE, random_reading());
      push_req(CMD_SAMPLE, random_reading());
      // restart while a run is active
      push_req(CMD_START, flat_reading(16'h8000));
      push_req(CMD_SAMPLE, {16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h7fff, 16'h8000});
      push_req(CMD_START, flat_reading(16'h0000));

      for (run_idx = 0; run_idx < NUM_RUNS; run_idx++) begin
         if (run_idx > 0) setup_run(run_idx);
         quiet = (run_idx == NUM_RUNS - 1);
         run_calibration();
      end

      drain();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
